/* sv/tbc_pkg.sv */
// Package: shared widths, map geometry and register indexes of the tile-map box collision block.
`timescale 1ns / 1ps

package tbc_pkg;

  // Map geometry
  localparam int unsigned MAP_ROWS = 32;
  localparam int unsigned MAP_COLS = 256;
  localparam int unsigned ROW_W    = $clog2(MAP_ROWS);
  localparam int unsigned COL_W    = $clog2(MAP_COLS);

  // Beat field widths
  localparam int unsigned TILE_W   = 8;
  localparam int unsigned COORD_W  = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_HALF_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HALF_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE     = 3'd4;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Tile code that marks a solid cell
  localparam logic [TILE_W-1:0] TILE_SOLID = 8'd1;

endpackage

/* sv/tbc_if.sv */
// Interfaces: item, result and configuration channels of the collision block.
`timescale 1ns / 1ps

interface tbc_item_if;
  import tbc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic        [ROW_W-1:0]   cell_row;
  logic        [COL_W-1:0]   cell_col;
  logic        [TILE_W-1:0]  tile_code;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;

  modport source (output valid, mode, cell_row, cell_col, tile_code, center_x, center_y,
                  input ready);
  modport sink   (input valid, mode, cell_row, cell_col, tile_code, center_x, center_y,
                  output ready);
endinterface

interface tbc_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

interface tbc_cfg_if;
  import tbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/tilemap_box_collision_core.sv */
// Top level: tile-map box collision with a shared restoring divider and a row-wide map scan.
`timescale 1ns / 1ps

// The block keeps a 32 x 256 map of solid bits, stored as one 256-bit word per row.
// A write beat (mode 0) updates one bit and is done in the cycle it is accepted.
// A query beat (mode 1) turns the box edges into column and row index bounds with
// one shared 16-step restoring divider by cell_size, run four times, then reads one
// map row per cycle across the overlapped rows in use, ANDs it with the column mask
// and ORs the result into hit, which is then loaded into the output register. With
// zero cell size the divider is skipped. The input is not ready while a query runs
// and is ready again right after the hit beat is raised.
// The hit beat waits in an output register, and the next item is taken meanwhile;
// a query that finishes while that register is still full holds until it is taken.
// Map cells have no reset; a query must only cover cells that were written.
module tilemap_box_collision_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  tbc_item_if.sink     item_i,
  tbc_result_if.source result_o,
  tbc_cfg_if.sink      cfg_i
);
  import tbc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int unsigned EDGE_W = COORD_W + 2;
  localparam int unsigned NC_W   = COL_W + 1;
  localparam int unsigned NR_W   = ROW_W + 1;
  localparam int unsigned STEP_W = $clog2(COORD_W);

  // Clip a quotient to a bound count
  function automatic logic [NC_W-1:0] clip_cols(input logic [COORD_W:0] q,
                                                input logic [NC_W-1:0] lim);
    logic [NC_W-1:0] res;
    res = (q >= (COORD_W+1)'(lim)) ? lim : q[NC_W-1:0];
    return res;
  endfunction

  function automatic logic [NR_W-1:0] clip_rows(input logic [COORD_W:0] q,
                                                input logic [NR_W-1:0] lim);
    logic [NR_W-1:0] res;
    res = (q >= (COORD_W+1)'(lim)) ? lim : q[NR_W-1:0];
    return res;
  endfunction

  // Configuration registers
  logic [9:0] half_w_q, half_h_q;
  logic [7:0] cell_size_q;
  logic [5:0] rows_use_q;
  logic [8:0] cols_use_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q    <= 10'd30;
      half_h_q    <= 10'd30;
      cell_size_q <= 8'd64;
      rows_use_q  <= 6'd32;
      cols_use_q  <= 9'd256;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_BOX_HALF_WIDTH:  half_w_q    <= cfg_i.data[9:0];
        REG_BOX_HALF_HEIGHT: half_h_q    <= cfg_i.data[9:0];
        REG_CELL_SIZE:       cell_size_q <= cfg_i.data[7:0];
        REG_ROWS_IN_USE:     rows_use_q  <= cfg_i.data[5:0];
        REG_COLS_IN_USE:     cols_use_q  <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  // Effective scan limits
  logic [NR_W-1:0] nr_lim;
  logic [NC_W-1:0] nc_lim;
  assign nr_lim = (rows_use_q > NR_W'(MAP_ROWS)) ? NR_W'(MAP_ROWS) : rows_use_q;
  assign nc_lim = (cols_use_q > NC_W'(MAP_COLS)) ? NC_W'(MAP_COLS) : cols_use_q;

  // Control and datapath registers
  logic [1:0]               state_q, state_d;
  logic signed [EDGE_W-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic [1:0]               op_q;
  logic [STEP_W-1:0]        step_q;
  logic [COORD_W-1:0]       dvd_q, quo_q;
  logic [7:0]               rem_q;
  logic [NC_W-1:0]          col_lo_q, col_hi_q;
  logic [NR_W-1:0]          row_hi_q, row_q;
  logic                     pend_q, hit_q;
  logic                     res_vld_q, res_hit_q;

  logic item_acc, res_free, rd_en;
  assign item_i.ready = (state_q == ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign res_free     = !res_vld_q || result_o.ready;
  assign result_o.valid = res_vld_q;
  assign result_o.hit   = res_hit_q;

  // Edge signs used for dividend selection and bound overrides
  logic xmin_neg, xmax_pos, ymin_neg, ymax_pos;
  assign xmin_neg = xmin_q < 0;
  assign xmax_pos = xmax_q > 0;
  assign ymin_neg = ymin_q < 0;
  assign ymax_pos = ymax_q > 0;

  // Dividend for each divider pass: low edge, or high edge minus one
  function automatic logic [COORD_W-1:0] pick_dvd(input logic [1:0] op,
      input logic signed [EDGE_W-1:0] xmn, input logic signed [EDGE_W-1:0] xmx,
      input logic signed [EDGE_W-1:0] ymn, input logic signed [EDGE_W-1:0] ymx);
    logic [EDGE_W-1:0] v;
    logic [COORD_W-1:0] res;
    case (op)
      2'd0:    v = (xmn < 0) ? '0 : xmn;
      2'd1:    v = (xmx > 0) ? xmx - EDGE_W'(1) : '0;
      2'd2:    v = (ymn < 0) ? '0 : ymn;
      default: v = (ymx > 0) ? ymx - EDGE_W'(1) : '0;
    endcase
    res = v[COORD_W-1:0];
    return res;
  endfunction

  // Shared restoring divider step; the first step of a pass starts from the
  // picked dividend with a clear remainder and quotient
  logic [COORD_W-1:0] dvd_pick, dvd_cur, quo_cur;
  logic [7:0]         rem_cur;
  logic [8:0]         div_t, div_sub;
  logic               div_ge;
  logic [COORD_W-1:0] quo_fin;
  logic [COORD_W:0]   quo_inc;
  assign dvd_pick = pick_dvd(op_q, xmin_q, xmax_q, ymin_q, ymax_q);
  assign dvd_cur  = (step_q == '0) ? dvd_pick : dvd_q;
  assign rem_cur  = (step_q == '0) ? '0 : rem_q;
  assign quo_cur  = (step_q == '0) ? '0 : quo_q;
  assign div_t    = {rem_cur, dvd_cur[COORD_W-1]};
  assign div_sub  = div_t - {1'b0, cell_size_q};
  assign div_ge   = div_t >= {1'b0, cell_size_q};
  assign quo_fin  = {quo_cur[COORD_W-2:0], div_ge};
  assign quo_inc  = {1'b0, quo_fin} + (COORD_W+1)'(1);

  // Column mask over the whole row word
  logic [MAP_COLS-1:0] col_mask;
  always_comb begin
    for (int c = 0; c < MAP_COLS; c++) begin
      col_mask[c] = (NC_W'(c) >= col_lo_q) && (NC_W'(c) < col_hi_q);
    end
  end

  assign rd_en = (state_q == ST_SCAN) && (row_q < row_hi_q);

  // Map memory: bit write, row read
  logic [MAP_COLS-1:0] map_mem [MAP_ROWS];
  logic [MAP_COLS-1:0] row_data_q;

  always_ff @(posedge clk_i) begin
    if (item_acc && item_i.mode == MODE_WRITE) begin
      map_mem[item_i.cell_row][item_i.cell_col] <= (item_i.tile_code == TILE_SOLID);
    end
    if (rd_en) begin
      row_data_q <= map_mem[row_q[ROW_W-1:0]];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (item_acc && item_i.mode == MODE_QUERY) state_d = ST_DIV;
      ST_DIV:  if (cell_size_q == '0 || (op_q == 2'd3 && step_q == STEP_W'(COORD_W-1)))
                 state_d = ST_SCAN;
      ST_SCAN: if (!rd_en && !pend_q) state_d = ST_DONE;
      ST_DONE: if (res_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (state_q == ST_DONE && res_free) begin
        res_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          xmin_q <= EDGE_W'(item_i.center_x) - $signed({8'd0, half_w_q});
          xmax_q <= EDGE_W'(item_i.center_x) + $signed({8'd0, half_w_q});
          ymin_q <= EDGE_W'(item_i.center_y) - $signed({8'd0, half_h_q});
          ymax_q <= EDGE_W'(item_i.center_y) + $signed({8'd0, half_h_q});
          op_q   <= 2'd0;
          step_q <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
          hit_q  <= 1'b0;
        end
      end
      ST_DIV: begin
        if (cell_size_q == '0) begin
          // Zero cell size: every cell is the point at the origin
          col_lo_q <= '0;
          col_hi_q <= (xmin_neg && xmax_pos) ? nc_lim : '0;
          row_hi_q <= (ymin_neg && ymax_pos) ? nr_lim : '0;
          row_q    <= '0;
        end else begin
          quo_q  <= quo_fin;
          rem_q  <= div_ge ? div_sub[7:0] : div_t[7:0];
          dvd_q  <= {dvd_cur[COORD_W-2:0], 1'b0};
          // wraps to zero after the last step of a pass
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(COORD_W-1)) begin
            unique case (op_q)
              2'd0: col_lo_q <= clip_cols({1'b0, quo_fin}, NC_W'(MAP_COLS));
              2'd1: col_hi_q <= xmax_pos ? clip_cols(quo_inc, nc_lim) : '0;
              2'd2: row_q    <= clip_rows({1'b0, quo_fin}, NR_W'(MAP_ROWS));
              default: row_hi_q <= ymax_pos ? clip_rows(quo_inc, nr_lim) : '0;
            endcase
            op_q <= op_q + 2'd1;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          row_q <= row_q + NR_W'(1);
        end
        if (pend_q) begin
          hit_q <= hit_q | (|(row_data_q & col_mask));
        end
      end
      ST_DONE: begin
        if (res_free) begin
          res_hit_q <= hit_q;
        end
      end
      default: ;
    endcase
  end

endmodule

/* tb/tb_top.sv */
// Testbench: self-checking run of the tile-map box collision core with its own map and box predictor.
`timescale 1ns / 1ps

module tb_top;
  import tbc_pkg::*;

  // Idle wait for a query to finish, with some margin, before touching registers
  localparam int unsigned QUERY_LAT = 120;
  // Rows other than row 0 are written only across this many leading columns
  localparam int unsigned NARROW_COLS = 2;

  typedef struct {
    logic                      mode;
    logic        [ROW_W-1:0]   row;
    logic        [COL_W-1:0]   col;
    logic        [TILE_W-1:0]  code;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } map_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tbc_item_if   item_if ();
  tbc_result_if res_if ();
  tbc_cfg_if    cfg_if ();

  tilemap_box_collision_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // Predictor copy of the solid map and of the registers
  bit         solid_map [MAP_ROWS][MAP_COLS];
  logic [9:0] cfg_half_w = 10'd30;
  logic [9:0] cfg_half_h = 10'd30;
  logic [7:0] cfg_cell   = 8'd64;
  logic [5:0] cfg_rows   = 6'd32;
  logic [8:0] cfg_cols   = 9'd256;

  bit          expected_hits [$];
  int unsigned mismatch_count = 0;

  // Traffic shaping knobs
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          cfg_noise = 1'b0;
  int unsigned rx_hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  // Hit bit for a box centred at (cx, cy) against the solid cells in use
  function automatic bit box_hits_map(input logic signed [COORD_W-1:0] cx,
                                      input logic signed [COORD_W-1:0] cy);
    int xlo, xhi, ylo, yhi, cs, nr, nc;
    xlo = int'(cx) - int'(cfg_half_w);
    xhi = int'(cx) + int'(cfg_half_w);
    ylo = int'(cy) - int'(cfg_half_h);
    yhi = int'(cy) + int'(cfg_half_h);
    cs  = int'(cfg_cell);
    nr  = (cfg_rows > MAP_ROWS) ? MAP_ROWS : int'(cfg_rows);
    nc  = (cfg_cols > MAP_COLS) ? MAP_COLS : int'(cfg_cols);
    for (int r = 0; r < nr; r++) begin
      if (!(ylo < r * cs + cs && yhi > r * cs)) continue;
      for (int c = 0; c < nc; c++) begin
        if (solid_map[r][c] && xlo < c * cs + cs && xhi > c * cs) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic map_item_t query_item(input logic signed [COORD_W-1:0] cx,
                                           input logic signed [COORD_W-1:0] cy);
    map_item_t it;
    it.mode = MODE_QUERY;
    it.row  = ROW_W'($urandom);
    it.col  = COL_W'($urandom);
    it.code = TILE_W'($urandom);
    it.cx   = cx;
    it.cy   = cy;
    return it;
  endfunction

  function automatic map_item_t write_item(input int r, input int c, input int code);
    map_item_t it;
    it.mode = MODE_WRITE;
    it.row  = ROW_W'(r);
    it.col  = COL_W'(c);
    it.code = TILE_W'(code);
    it.cx   = COORD_W'($urandom);
    it.cy   = COORD_W'($urandom);
    return it;
  endfunction

  // Solid with the given percentage, otherwise any other code
  function automatic int pick_tile_code(input int density);
    int code;
    if (int'($urandom_range(0, 99)) < density) return int'(TILE_SOLID);
    do code = $urandom_range(0, 255); while (code == int'(TILE_SOLID));
    return code;
  endfunction

  // Cell write inside the region that the fill pass covers
  function automatic map_item_t random_write(input int density);
    int r, c;
    if ($urandom_range(0, 1)) begin
      r = 0;
      c = $urandom_range(0, MAP_COLS - 1);
    end else begin
      r = $urandom_range(0, MAP_ROWS - 1);
      c = $urandom_range(0, NARROW_COLS - 1);
    end
    return write_item(r, c, pick_tile_code(density));
  endfunction

  // Centre coordinate: mostly around the map, some on cell edges, some anywhere
  function automatic logic signed [COORD_W-1:0] pick_coord(input int cells, input int half,
                                                           input int cs);
    int lo, hi, v;
    case ($urandom_range(0, 7))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1, 2: begin
        v = int'($urandom_range(0, cells)) * cs + ($urandom_range(0, 1) ? half : -half)
            + int'($urandom_range(0, 2)) - 1;
      end
      default: begin
        lo = -(half + cs + 4);
        hi = cells * cs + half + cs + 4;
        v  = lo + int'($urandom_range(0, hi - lo));
      end
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[COORD_W-1:0];
  endfunction

  function automatic map_item_t random_query();
    int nr, nc;
    nr = (cfg_rows > MAP_ROWS) ? MAP_ROWS : int'(cfg_rows);
    nc = (cfg_cols > MAP_COLS) ? MAP_COLS : int'(cfg_cols);
    return query_item(pick_coord(nc, int'(cfg_half_w), int'(cfg_cell)),
                      pick_coord(nr, int'(cfg_half_h), int'(cfg_cell)));
  endfunction

  // Register data with random bits above the field when noise is on
  function automatic logic [CFG_DATA_W-1:0] noisy(input int value, input int width);
    logic [CFG_DATA_W-1:0] upper;
    upper = cfg_noise ? CFG_DATA_W'($urandom) : '0;
    return (upper << width) | CFG_DATA_W'(value);
  endfunction

  // Send one item beat; the predictor is updated at the accepting edge
  task automatic send_item(input map_item_t it);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.mode      <= it.mode;
    item_if.cell_row  <= it.row;
    item_if.cell_col  <= it.col;
    item_if.tile_code <= it.code;
    item_if.center_x  <= it.cx;
    item_if.center_y  <= it.cy;
    do @(posedge clk_i); while (!item_if.ready);
    if (it.mode == MODE_WRITE) solid_map[it.row][it.col] = (it.code == TILE_SOLID);
    else expected_hits.push_back(box_hits_map(it.cx, it.cy));
  endtask

  // Stop sending, wait for every pending hit, then let the block go idle
  task automatic settle();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (QUERY_LAT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_BOX_HALF_WIDTH:  cfg_half_w = data[9:0];
      REG_BOX_HALF_HEIGHT: cfg_half_h = data[9:0];
      REG_CELL_SIZE:       cfg_cell   = data[7:0];
      REG_ROWS_IN_USE:     cfg_rows   = data[5:0];
      REG_COLS_IN_USE:     cfg_cols   = data[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_setting(input int hw, input int hh, input int cs, input int rows,
                               input int cols);
    write_reg(REG_BOX_HALF_WIDTH,  noisy(hw, 10));
    write_reg(REG_BOX_HALF_HEIGHT, noisy(hh, 10));
    write_reg(REG_CELL_SIZE,       noisy(cs, 8));
    write_reg(REG_ROWS_IN_USE,     noisy(rows, 6));
    write_reg(REG_COLS_IN_USE,     noisy(cols, 9));
  endtask

  // Random mix of queries and cell writes
  task automatic run_mixed(input int count, input int query_pct, input int density);
    for (int i = 0; i < count; i++) begin
      if (int'($urandom_range(0, 99)) < query_pct) send_item(random_query());
      else send_item(random_write(density));
    end
  endtask

  // Row 0 is written across every column, the other rows across the leading columns;
  // every setting keeps its scan inside that region, so no query reads an unset cell
  task automatic test_fill_map();
    int density;
    int ncols;
    for (int r = 0; r < MAP_ROWS; r++) begin
      tx_steady = (r % 4 != 0);
      density   = (r % 3 == 1) ? 0 : ((r % 3 == 2) ? 10 : 35);
      ncols     = (r == 0) ? MAP_COLS : NARROW_COLS;
      for (int c = 0; c < ncols; c++) send_item(write_item(r, c, pick_tile_code(density)));
    end
    tx_steady = 1'b0;
    settle();
  endtask

  // Default box and cell: tile codes around the origin, touching boxes, coordinate extremes
  task automatic test_directed();
    apply_setting(30, 30, 64, MAP_ROWS, NARROW_COLS);
    send_item(write_item(0, 0, TILE_SOLID));
    send_item(write_item(0, 1, 2));
    send_item(write_item(1, 0, 255));
    send_item(write_item(1, 1, 0));
    send_item(write_item(MAP_ROWS - 1, NARROW_COLS - 1, TILE_SOLID));
    send_item(query_item(0, 0));
    send_item(query_item(-30, -30));      // corner touch only
    send_item(query_item(-29, -29));
    send_item(query_item(-29, -30));      // edge touch on y
    send_item(query_item(32, 32));
    send_item(query_item(94, 94));        // touches the solid origin cell
    send_item(query_item(96, 2016));      // last written cell of the bottom row
    send_item(query_item(-32768, -32768));
    send_item(query_item(32767, 32767));
    send_item(query_item(-32768, 32767));
    send_item(query_item(32767, -32768));
    settle();
  endtask

  // Register extremes: zero and full sizes, collapsed cells, empty and oversized scans
  task automatic test_config_extremes();
    int unsigned sets [10][5] = '{
      '{0, 0, 1, 1, 1},
      '{1023, 1023, 255, 1, 256},
      '{1023, 1023, 1, 32, 2},
      '{0, 0, 255, 32, 2},
      '{5, 7, 0, 32, 2},
      '{30, 30, 64, 0, 256},
      '{30, 30, 64, 32, 0},
      '{100, 20, 16, 63, 2},
      '{100, 20, 1, 1, 511},
      '{0, 1023, 3, 17, 2}
    };
    for (int s = 0; s < 10; s++) begin
      apply_setting(sets[s][0], sets[s][1], sets[s][2], sets[s][3], sets[s][4]);
      rx_steady = (s % 3 == 0);
      run_mixed(12, 80, 30);
      settle();
    end
    rx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int hw, hh, cs, rows, cols;
    for (int p = 0; p < 8; p++) begin
      cfg_noise = ($urandom_range(0, 3) == 0);
      hw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 80);
      hh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 80);
      case ($urandom_range(0, 9))
        0:       cs = 0;
        1, 2:    cs = $urandom_range(1, 8);
        3:       cs = 255;
        default: cs = $urandom_range(9, 254);
      endcase
      // Wide scans stay on row 0, tall scans on the leading columns
      case ($urandom_range(0, 3))
        0: begin
          rows = $urandom_range(0, 1);
          cols = $urandom_range(0, 511);
        end
        1: begin
          rows = $urandom_range(33, 63);
          cols = $urandom_range(0, NARROW_COLS);
        end
        default: begin
          rows = $urandom_range(1, 32);
          cols = $urandom_range(1, NARROW_COLS);
        end
      endcase
      apply_setting(hw, hh, cs, rows, cols);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      run_mixed(15, 65, $urandom_range(0, 40));
      settle();
    end
    cfg_noise = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result side holds off for a long stretch while queries keep coming
  task automatic test_backpressure();
    apply_setting(30, 30, 64, MAP_ROWS, NARROW_COLS);
    rx_hold_cycles = 600;
    tx_steady      = 1'b1;
    for (int i = 0; i < 10; i++) send_item(random_query());
    tx_steady = 1'b0;
    settle();
  endtask

  // Result sink: random stall per beat, or one long counted hold on request
  initial begin : result_drain
    int unsigned pause;
    bit          long_hold;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    res_if.ready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
      long_hold      = (rx_hold_cycles != 0);
      pause          = long_hold ? rx_hold_cycles : (rx_steady ? 0 : $urandom_range(0, 13));
      rx_hold_cycles = 0;
      if (pause > 0) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        if (!long_hold) while (!res_if.valid) @(negedge clk_i);
        repeat (pause) @(negedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each hit beat with the oldest pending query
  always @(posedge clk_i) begin : hit_check
    bit want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_hits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: hit beat with no query pending, actual %0b", $realtime, res_if.hit);
      end else begin
        want = expected_hits.pop_front();
        if (res_if.hit !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: hit mismatch, expected %0b actual %0b", $realtime, want, res_if.hit);
        end
      end
    end
  end

  initial begin : stimulus
    item_if.valid     = 1'b0;
    item_if.mode      = MODE_WRITE;
    item_if.cell_row  = '0;
    item_if.cell_col  = '0;
    item_if.tile_code = '0;
    item_if.center_x  = '0;
    item_if.center_y  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill_map();
    test_directed();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();

    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #15ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* sim.f */
sv/tbc_pkg.sv
sv/tbc_if.sv
sv/tilemap_box_collision_core.sv
tb/tb_top.sv
